// ===== src/broken_down_time_to_epoch_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the date-to-epoch converter
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BROKEN_DOWN_TIME_TO_EPOCH_TOP_ASSERT_SVH
`define BROKEN_DOWN_TIME_TO_EPOCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, ignored while reset is high
`define BDTE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdte: implication check failed");

// next-cycle implication, checked through reset as well
`define BDTE_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bdte: next-cycle check failed");

`else

`define BDTE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BDTE_ASSERT_NEXT(label, clk, ante, cons)

`endif

`endif

// ===== src/bdte_pkg.sv =====
// ----------------------------------------------------------------------------
// bdte_pkg
// Types, calendar constants and helper functions for the epoch converter.
// ----------------------------------------------------------------------------
package bdte_pkg;

  localparam logic [5:0]  SEC_MAX        = 6'd59;
  localparam logic [5:0]  MIN_MAX        = 6'd59;
  localparam logic [4:0]  HOUR_MAX       = 5'd23;
  localparam logic [3:0]  MONTH_MAX      = 4'd11;
  localparam logic [3:0]  MONTH_FEB      = 4'd1;
  localparam logic [7:0]  YEAR_FIRST     = 8'd70;
  localparam logic [7:0]  YEAR_LAST      = 8'd205;
  localparam logic [7:0]  YEAR_LEAP_BASE = 8'd69;
  localparam logic [7:0]  YEAR_2001      = 8'd101;
  localparam logic [7:0]  YEAR_2101      = 8'd201;
  localparam logic [7:0]  YEAR_2100      = 8'd200;
  localparam logic [15:0] MONTH31_MASK   = 16'h0AD5;
  localparam logic [15:0] DAYS_PER_YEAR  = 16'd365;
  localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN   = 17'd60;
  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [16:0] EPOCH_WEEKDAY  = 17'd4;
  localparam logic [31:0] EPOCH_INVALID  = 32'hFFFF_FFFF;

  // stage 1 -> stage 2
  typedef struct packed {
    logic [15:0] year_days;
    logic [8:0]  yday;
    logic [16:0] tod;
    logic        ok;
  } date_parts_t;

  // stage 2 -> stage 3 (inside the day unit)
  typedef struct packed {
    logic [15:0] days;
    logic [8:0]  yday;
    logic [16:0] tod;
    logic        ok;
  } day_count_t;

  // stage 3 -> output stage
  typedef struct packed {
    logic [31:0] day_secs;
    logic [2:0]  weekday;
    logic [8:0]  yday;
    logic [16:0] tod;
    logic        ok;
  } day_secs_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // 8 is 1 mod 7, so octal digit sums keep the remainder
  function automatic logic [2:0] mod7(input logic [16:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
       + 6'(x[16:15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
  endfunction

endpackage

// ===== src/broken_down_time_to_epoch_top.sv =====
// Throughput: one transaction per cycle; the four stages advance together and
// freeze only while the output register holds a result that is not taken.
// The day-count multiply by 86400 sets the stage depth.
// Reset clears all stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
// broken_down_time_to_epoch_top
// Converts a broken-down UTC date and time into seconds since 1970-01-01,
// with day of year, weekday and a validity flag.
// ----------------------------------------------------------------------------
`include "broken_down_time_to_epoch_top_assert.svh"

module broken_down_time_to_epoch_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // second[5:0], minute[11:6], hour[16:12], day_of_month[21:17],
  // month[25:22], year_since_1900[33:26], zero[39:34]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // epoch_seconds[31:0], day_of_year[40:32], weekday[43:41],
  // valid_res[44], zero[47:45]
  output logic [47:0] m_tdata
);
  import bdte_pkg::*;

  logic        en;
  logic        f_valid;
  date_parts_t parts;
  logic        d_valid;
  day_secs_t   secs;

  logic [31:0] epoch_seconds;
  logic [8:0]  day_of_year;
  logic [2:0]  weekday;
  logic        valid_res;

  // advance every stage unless the output holds an untaken result
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  bdte_field_stage u_field (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (s_tvalid),
    .second          (s_tdata[5:0]),
    .minute          (s_tdata[11:6]),
    .hour            (s_tdata[16:12]),
    .day_of_month    (s_tdata[21:17]),
    .month           (s_tdata[25:22]),
    .year_since_1900 (s_tdata[33:26]),
    .out_valid       (f_valid),
    .parts           (parts)
  );

  bdte_day_stage u_day (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .parts     (parts),
    .out_valid (d_valid),
    .secs      (secs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (secs.ok) begin
        epoch_seconds <= secs.day_secs + 32'(secs.tod);
        day_of_year   <= secs.yday;
        weekday       <= secs.weekday;
      end else begin
        epoch_seconds <= EPOCH_INVALID;
        day_of_year   <= 9'd0;
        weekday       <= 3'd0;
      end
      valid_res <= secs.ok;
    end
  end

  assign m_tdata = {3'b000, valid_res, weekday, day_of_year, epoch_seconds};

  `BDTE_ASSERT_IMPLY(a_invalid_all_ones, clk, rst, m_tvalid && !valid_res, epoch_seconds == EPOCH_INVALID)
  `BDTE_ASSERT_IMPLY(a_invalid_zeros, clk, rst, m_tvalid && !valid_res, (day_of_year == 9'd0) && (weekday == 3'd0))
  `BDTE_ASSERT_IMPLY(a_valid_ranges, clk, rst, m_tvalid && valid_res, (day_of_year <= 9'd365) && (weekday <= 3'd6))
  `BDTE_ASSERT_NEXT(a_reset_empty, clk, rst, !m_tvalid && !f_valid && !d_valid)

endmodule

// ===== src/bdte_field_stage.sv =====
// ----------------------------------------------------------------------------
// bdte_field_stage
// First stage: range checks, month length, day of year, year offset in days
// and time of day in seconds.
// ----------------------------------------------------------------------------
module bdte_field_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [5:0]           second,
  input  logic [5:0]           minute,
  input  logic [4:0]           hour,
  input  logic [4:0]           day_of_month,
  input  logic [3:0]           month,
  input  logic [7:0]           year_since_1900,
  output logic                 out_valid,
  output bdte_pkg::date_parts_t parts
);
  import bdte_pkg::*;

  logic        leap;
  logic [4:0]  mlen;
  logic        ok;
  logic [7:0]  year_off;
  logic [7:0]  leap_cnt;
  logic [15:0] c100;
  logic [15:0] c400;
  date_parts_t parts_next;

  always_comb begin
    // 1900 is outside the range, 2000 is a leap year, 2100 is not
    leap = (year_since_1900[1:0] == 2'b00) && (year_since_1900 != YEAR_2100);
    if (month == MONTH_FEB) begin
      mlen = 5'd28 + 5'(leap);
    end else begin
      mlen = 5'd30 + 5'(MONTH31_MASK[month]);
    end
    ok = (second <= SEC_MAX) && (minute <= MIN_MAX) && (hour <= HOUR_MAX) &&
         (day_of_month != 5'd0) && (month <= MONTH_MAX) &&
         (year_since_1900 >= YEAR_FIRST) && (year_since_1900 <= YEAR_LAST) &&
         (day_of_month <= mlen);

    year_off = year_since_1900 - YEAR_FIRST;
    leap_cnt = 8'(year_since_1900 - YEAR_LEAP_BASE) >> 2;
    c100 = 16'(year_since_1900 >= YEAR_2001) + 16'(year_since_1900 >= YEAR_2101);
    c400 = 16'(year_since_1900 >= YEAR_2001);

    parts_next.year_days = 16'(16'(year_off) * DAYS_PER_YEAR) + 16'(leap_cnt)
                         - c100 + c400;
    parts_next.yday = days_before_month(month) + 9'(leap && (month > MONTH_FEB))
                    + 9'(day_of_month) - 9'd1;
    parts_next.tod = 17'(17'(hour) * SECS_PER_HOUR) + 17'(17'(minute) * SECS_PER_MIN)
                   + 17'(second);
    parts_next.ok = ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      parts <= parts_next;
    end
  end

endmodule

// ===== src/bdte_day_stage.sv =====
// ----------------------------------------------------------------------------
// bdte_day_stage
// Second and third stages: day count since the epoch, then its product with
// the seconds per day and the weekday.
// ----------------------------------------------------------------------------
module bdte_day_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  bdte_pkg::date_parts_t parts,
  output logic                  out_valid,
  output bdte_pkg::day_secs_t   secs
);
  import bdte_pkg::*;

  logic       cnt_valid;
  day_count_t cnt;
  day_count_t cnt_next;
  day_secs_t  secs_next;

  always_comb begin
    cnt_next.days = parts.year_days + 16'(parts.yday);
    cnt_next.yday = parts.yday;
    cnt_next.tod  = parts.tod;
    cnt_next.ok   = parts.ok;
  end

  always_comb begin
    secs_next.day_secs = 32'(32'(cnt.days) * 32'(SECS_PER_DAY));
    secs_next.weekday  = mod7(17'(cnt.days) + EPOCH_WEEKDAY);
    secs_next.yday     = cnt.yday;
    secs_next.tod      = cnt.tod;
    secs_next.ok       = cnt.ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      cnt_valid <= in_valid;
      out_valid <= cnt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt  <= cnt_next;
      secs <= secs_next;
    end
  end

endmodule

// ===== bench/tb_broken_down_time_to_epoch_top.sv =====
// ----------------------------------------------------------------------------
// tb_broken_down_time_to_epoch_top
// Self-checking bench for the date-to-epoch converter. A short table of
// directed dates comes first: calendar extremes, every out-of-range field,
// days past the month end, and leap days around century years. A long run of
// random dates follows, mostly well-formed with some broken ones and raw
// noise mixed in. A behavioral calendar computes the expected seconds, day of
// year and weekday for the random dates and the untyped table rows. Both stream
// sides stall at random, except for one stretch where they run at full rate.
// ----------------------------------------------------------------------------
module tb_broken_down_time_to_epoch_top;
  import bdte_pkg::*;

  localparam int unsigned DAY_SECONDS  = 86400;
  localparam int unsigned RANDOM_DATES = 1500;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned IDLE_PCT     = 35;

  // input transaction, from the lowest bit up: second, minute, hour,
  // day_of_month, month, year_since_1900, zero fill
  typedef struct packed {
    logic [5:0] fill;
    logic [7:0] year_since_1900;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } date_word_t;

  // output transaction, from the lowest bit up: epoch_seconds, day_of_year,
  // weekday, valid_res, zero fill
  typedef struct packed {
    logic [2:0]  fill;
    logic        valid_res;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic [31:0] epoch_seconds;
  } epoch_word_t;

  typedef struct {
    date_word_t  date;
    bit          typed;
    epoch_word_t want;
  } date_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  epoch_word_t pending_q[$];
  epoch_word_t offered = '0;
  date_row_t   date_rows[$];
  int unsigned dates_taken = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches = 0;

  // full-rate window on both sides
  wire calm = (dates_taken >= 600) && (dates_taken < 900);

  broken_down_time_to_epoch_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit leap_year(input int unsigned year);
    return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
  endfunction

  function automatic int unsigned month_len(input logic [3:0] mon, input bit leap);
    if (mon == MONTH_FEB)
      return leap ? 29 : 28;
    case (mon)
      4'd3, 4'd5, 4'd8, 4'd10: return 30;
      default:                 return 31;
    endcase
  endfunction

  // count whole years and months from 1970-01-01 by their lengths in days
  function automatic epoch_word_t predict_epoch(input date_word_t d);
    epoch_word_t     r;
    int unsigned     year;
    int unsigned     yday;
    longint unsigned days;
    bit              leap;
    r = '0;
    r.epoch_seconds = EPOCH_INVALID;
    year = 1900 + d.year_since_1900;
    leap = leap_year(year);
    if (d.second > SEC_MAX || d.minute > MIN_MAX || d.hour > HOUR_MAX ||
        d.month > MONTH_MAX || d.year_since_1900 < YEAR_FIRST ||
        d.year_since_1900 > YEAR_LAST || d.day_of_month == 0 ||
        d.day_of_month > month_len(d.month, leap))
      return r;
    yday = d.day_of_month - 1;
    for (int m = 0; m < d.month; m++)
      yday += month_len(4'(m), leap);
    days = yday;
    for (int unsigned y = 1970; y < year; y++)
      days += leap_year(y) ? 366 : 365;
    r.epoch_seconds = 32'(days * DAY_SECONDS + d.hour * 3600 + d.minute * 60 + d.second);
    r.day_of_year   = 9'(yday);
    r.weekday       = 3'((days + 4) % 7);
    r.valid_res     = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input int sec, input int min, input int hr,
                                  input int mday, input int mon, input int yr,
                                  input bit typed, input logic [31:0] secs,
                                  input int yday, input int wday, input bit ok);
    date_row_t row;
    row.date = '0;
    row.date.second          = 6'(sec);
    row.date.minute          = 6'(min);
    row.date.hour            = 5'(hr);
    row.date.day_of_month    = 5'(mday);
    row.date.month           = 4'(mon);
    row.date.year_since_1900 = 8'(yr);
    row.typed = typed;
    row.want  = '0;
    row.want.epoch_seconds = secs;
    row.want.day_of_year   = 9'(yday);
    row.want.weekday       = 3'(wday);
    row.want.valid_res     = ok;
    date_rows.push_back(row);
  endfunction

  task automatic offer_date(input date_word_t d, input epoch_word_t want);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    offered  <= want;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
  endtask

  always @(posedge clk)
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

  // log inputs as they are taken, check results as they leave
  always @(posedge clk) begin
    epoch_word_t got;
    epoch_word_t want;
    if (!rst && s_tvalid && s_tready) begin
      pending_q.push_back(offered);
      dates_taken <= dates_taken + 1;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: m_tdata %h", m_tdata);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (got.epoch_seconds !== want.epoch_seconds) begin
          $error("epoch_seconds: expected %0d, got %0d", want.epoch_seconds,
                 got.epoch_seconds);
          mismatches++;
        end
        if (got.day_of_year !== want.day_of_year) begin
          $error("day_of_year: expected %0d, got %0d", want.day_of_year, got.day_of_year);
          mismatches++;
        end
        if (got.weekday !== want.weekday) begin
          $error("weekday: expected %0d, got %0d", want.weekday, got.weekday);
          mismatches++;
        end
        if (got.valid_res !== want.valid_res) begin
          $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
          mismatches++;
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT)
      @(posedge clk);
    $display("tb_broken_down_time_to_epoch_top: FAIL");
    $finish;
  end

  initial begin
    date_word_t  d;
    int unsigned pick;
    int unsigned mlen;
    // first and last valid second of the range
    add_row(0, 0, 0, 1, 0, 70, 1, 32'd0, 0, 4, 1);
    add_row(59, 59, 23, 31, 11, 205, 1, 32'd4291747199, 364, 4, 1);
    // each field just out of range, then everything saturated, then year 1900
    add_row(60, 0, 0, 1, 0, 70, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(0, 60, 0, 1, 0, 70, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(0, 0, 24, 1, 0, 70, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 70, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(0, 0, 0, 1, 12, 70, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(0, 0, 0, 1, 0, 69, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(0, 0, 0, 1, 0, 206, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(63, 63, 31, 31, 15, 255, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(0, 0, 0, 1, 0, 0, 1, EPOCH_INVALID, 0, 0, 0);
    // days past the month end: plain year, century year, short months
    add_row(0, 0, 0, 29, 1, 70, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(0, 0, 0, 29, 1, 200, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(0, 0, 0, 31, 3, 100, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(0, 0, 0, 31, 10, 100, 1, EPOCH_INVALID, 0, 0, 0);
    add_row(0, 0, 0, 30, 1, 100, 1, EPOCH_INVALID, 0, 0, 0);
    // leap days and month ends, checked against the calendar
    add_row(12, 34, 5, 29, 1, 100, 0, '0, 0, 0, 0);
    add_row(59, 59, 23, 29, 1, 204, 0, '0, 0, 0, 0);
    add_row(0, 0, 0, 31, 11, 100, 0, '0, 0, 0, 0);
    add_row(0, 0, 0, 1, 2, 200, 0, '0, 0, 0, 0);
    add_row(30, 30, 12, 31, 6, 138, 0, '0, 0, 0, 0);
    add_row(7, 14, 3, 31, 7, 171, 0, '0, 0, 0, 0);
    add_row(0, 0, 0, 30, 8, 170, 0, '0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (date_rows[i])
      offer_date(date_rows[i].date,
                 date_rows[i].typed ? date_rows[i].want : predict_epoch(date_rows[i].date));

    repeat (RANDOM_DATES) begin
      d = '0;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0)
        d.year_since_1900 = $urandom_range(0, 1) ? YEAR_LAST : YEAR_FIRST;
      else
        d.year_since_1900 = 8'($urandom_range(YEAR_FIRST, YEAR_LAST));
      d.month  = 4'($urandom_range(0, MONTH_MAX));
      mlen     = month_len(d.month, leap_year(1900 + d.year_since_1900));
      d.day_of_month = 5'($urandom_range(1, mlen));
      d.hour   = 5'($urandom_range(0, HOUR_MAX));
      d.minute = 6'($urandom_range(0, MIN_MAX));
      d.second = 6'($urandom_range(0, SEC_MAX));
      if (pick >= 65 && pick < 80) begin
        // break exactly one field of a good date
        case ($urandom_range(0, 5))
          0: d.second = 6'($urandom_range(60, 63));
          1: d.minute = 6'($urandom_range(60, 63));
          2: d.hour   = 5'($urandom_range(24, 31));
          3: d.day_of_month = (mlen == 31) ? 5'd0 : 5'($urandom_range(mlen + 1, 31));
          4: d.month  = 4'($urandom_range(12, 15));
          default:
            d.year_since_1900 = $urandom_range(0, 1) ? 8'($urandom_range(0, 69))
                                                     : 8'($urandom_range(206, 255));
        endcase
      end else if (pick >= 80) begin
        d.second          = 6'($urandom());
        d.minute          = 6'($urandom());
        d.hour            = 5'($urandom());
        d.day_of_month    = 5'($urandom());
        d.month           = 4'($urandom());
        d.year_since_1900 = 8'($urandom());
      end
      offer_date(d, predict_epoch(d));
    end
    s_tvalid <= 1'b0;

    // wait until every offered transaction is logged and its result checked
    while ((dates_taken < date_rows.size() + RANDOM_DATES) || (pending_q.size() != 0))
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("tb_broken_down_time_to_epoch_top: PASS");
    else
      $display("tb_broken_down_time_to_epoch_top: FAIL");
    $finish;
  end

endmodule
